// File: design/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shorthand for the clocked concurrent assertions used in the RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// File: design/rk4s_pkg.sv
// ----------------------------------------------------------------------------
// rk4s_pkg
// Shared types, codes and saturation helpers of the RK4 rotor integrator.
// ----------------------------------------------------------------------------
`default_nettype none

package rk4s_pkg;

  localparam int VALUE_FRAC_BITS_DEF = 16;
  localparam int ANGLE_FRAC_BITS_DEF = 32;

  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 48;

  localparam logic [CFG_INDEX_W-1:0] REG_INERTIA       = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_DAMPING       = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_LOAD_TORQUE   = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_PROBE_ENABLED = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_INITIAL_ANGLE = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_INITIAL_SPEED = 3'd5;

  localparam logic signed [31:0] INERTIA_RESET = 32'sd65536;

  // Datapath operations issued by the controller.
  localparam logic [3:0] OP_NONE    = 4'd0;
  localparam logic [3:0] OP_ACCEPT  = 4'd1;
  localparam logic [3:0] OP_DMUL    = 4'd2;
  localparam logic [3:0] OP_NET     = 4'd3;
  localparam logic [3:0] OP_KSET    = 4'd4;
  localparam logic [3:0] OP_KMUL    = 4'd5;
  localparam logic [3:0] OP_WNEXT   = 4'd6;
  localparam logic [3:0] OP_HMUL    = 4'd7;
  localparam logic [3:0] OP_LMUL    = 4'd8;
  localparam logic [3:0] OP_PADD    = 4'd9;
  localparam logic [3:0] OP_XDIV    = 4'd10;
  localparam logic [3:0] OP_APPLY   = 4'd11;
  localparam logic [3:0] OP_PUBLISH = 4'd12;

  typedef struct packed {
    logic [3:0] op;
    logic [1:0] stage;
  } rk4s_cmd_t;

  typedef struct packed {
    logic integ;
    logic div_busy;
  } rk4s_stat_t;

  function automatic logic signed [31:0] sat32(input logic signed [67:0] x);
    logic signed [67:0] hi;
    logic signed [67:0] lo;
    hi = 68'sd2147483647;
    lo = -68'sd2147483648;
    if (x > hi) begin
      sat32 = 32'sh7fffffff;
    end else if (x < lo) begin
      sat32 = 32'sh80000000;
    end else begin
      sat32 = x[31:0];
    end
  endfunction

  function automatic logic signed [47:0] sat48(input logic signed [67:0] x);
    logic signed [67:0] hi;
    logic signed [67:0] lo;
    hi = 68'sd140737488355327;
    lo = -68'sd140737488355328;
    if (x > hi) begin
      sat48 = 48'sh7fffffffffff;
    end else if (x < lo) begin
      sat48 = 48'sh800000000000;
    end else begin
      sat48 = x[47:0];
    end
  endfunction

endpackage

`default_nettype wire

// File: design/rk4_rotor_dynamics_step.sv
// ----------------------------------------------------------------------------
// rk4_rotor_dynamics_step
// Fourth-order Runge-Kutta integrator of one rotor's angle and speed.
//
// Usage: configuration registers are written through cfg_we, cfg_index and
// cfg_data while the block is idle. An input beat is taken when in_valid is
// high and in_stall is low; each beat yields exactly one result beat, taken
// when out_valid is high and out_stall is low.
// A load beat or a skipped step goes on to publication as soon as it is
// taken. An integrating step runs four acceleration passes, each with a
// serial division by the inertia, and then two updates, each with a division
// by three. The divider and the one multiplier are shared by all passes, and
// the block works on one beat at a time, so the next beat is taken only once
// the result has been published.
// Reset loads the default configuration and clears angle, speed, held torque
// and the warning flag. A stalled result holds; a new beat is still taken and
// computed, and its result waits until the output register is free.
// ----------------------------------------------------------------------------
`default_nettype none

module rk4_rotor_dynamics_step #(
  parameter int VALUE_FRAC_BITS = rk4s_pkg::VALUE_FRAC_BITS_DEF,
  parameter int ANGLE_FRAC_BITS = rk4s_pkg::ANGLE_FRAC_BITS_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             cfg_we,
  input  wire logic [rk4s_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [rk4s_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  wire logic                             in_valid,
  output logic                                  in_stall,
  input  wire logic                             mode,
  input  wire logic signed [31:0]               time_step,
  input  wire logic                             torque_found,
  input  wire logic signed [31:0]               torque_value,
  output logic                                  out_valid,
  input  wire logic                             out_stall,
  output logic signed [47:0]                    rotor_angle,
  output logic signed [31:0]                    rotor_speed,
  output logic                                  integrated,
  output logic                                  probe_missing
);

  import rk4s_pkg::*;

  rk4s_cmd_t  cmd;
  rk4s_stat_t stat;

  rk4s_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  rk4s_datapath #(
    .VALUE_FRAC_BITS (VALUE_FRAC_BITS),
    .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .mode          (mode),
    .time_step     (time_step),
    .torque_found  (torque_found),
    .torque_value  (torque_value),
    .cmd           (cmd),
    .stat          (stat),
    .rotor_angle   (rotor_angle),
    .rotor_speed   (rotor_speed),
    .integrated    (integrated),
    .probe_missing (probe_missing)
  );

endmodule

`default_nettype wire

// File: design/rk4s_div.sv
// ----------------------------------------------------------------------------
// rk4s_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module rk4s_div (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic [63:0] dividend,
  input  wire logic [31:0] divisor,
  output logic             busy,
  output logic [63:0]      quot
);

  logic [5:0]  cnt;
  logic [31:0] rem;
  logic [32:0] trial;
  logic [32:0] diff;

  always_comb begin
    trial = {rem, quot[63]};
    diff  = trial - {1'b0, divisor};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= '0;
    end else if (busy) begin
      cnt <= cnt + 6'd1;
      if (cnt == 6'd63) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quot <= dividend;
      rem  <= '0;
    end else if (busy) begin
      if (!diff[32]) begin
        rem  <= diff[31:0];
        quot <= {quot[62:0], 1'b1};
      end else begin
        rem  <= trial[31:0];
        quot <= {quot[62:0], 1'b0};
      end
    end
  end

endmodule

`default_nettype wire

// File: design/rk4s_datapath.sv
// ----------------------------------------------------------------------------
// rk4s_datapath
// Configuration, rotor state, shared multiplier and divider of the integrator.
// ----------------------------------------------------------------------------
`default_nettype none

module rk4s_datapath #(
  parameter int VALUE_FRAC_BITS = rk4s_pkg::VALUE_FRAC_BITS_DEF,
  parameter int ANGLE_FRAC_BITS = rk4s_pkg::ANGLE_FRAC_BITS_DEF
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 cfg_we,
  input  wire logic [rk4s_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  wire logic [rk4s_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  wire logic                                 mode,
  input  wire logic signed [31:0]                   time_step,
  input  wire logic                                 torque_found,
  input  wire logic signed [31:0]                   torque_value,
  input  wire rk4s_pkg::rk4s_cmd_t                  cmd,
  output rk4s_pkg::rk4s_stat_t                      stat,
  output logic signed [47:0]                        rotor_angle,
  output logic signed [31:0]                        rotor_speed,
  output logic                                      integrated,
  output logic                                      probe_missing
);

  import rk4s_pkg::*;

  localparam int G  = VALUE_FRAC_BITS + 15 - ANGLE_FRAC_BITS;
  localparam int GP = (G > 0) ? G : 0;
  localparam int GM = (G < 0) ? -G : 0;

  // Reciprocal of three scaled by 2^19; exact for digits below 3 * 2^16.
  localparam logic [17:0] D3_RECIP = 18'd174763;

  // Configuration registers.
  logic signed [31:0] inertia, damping, load_torque, initial_speed;
  logic signed [47:0] initial_angle;
  logic               probe_enabled;

  // Rotor state and per-item working registers.
  logic signed [31:0] speed_reg, held_torque, torque, dt, cur_w, k;
  logic signed [47:0] angle_reg;
  logic               warned_flag, integ, missing, div_neg;
  logic signed [35:0] wsum, ssum;
  logic signed [65:0] prod, pacc, pval;

  // Division by three, 16 quotient bits per cycle.
  logic [63:0]        d3_x, d3_q;
  logic [1:0]         d3_r, d3_cnt;
  logic               d3_busy;
  logic [17:0]        d3_v, d3_rem;
  logic [35:0]        d3_m;
  logic [15:0]        d3_qc;

  // Combinational terms.
  logic signed [32:0] ma, mb;
  logic signed [65:0] mp;
  logic signed [67:0] p68, pv68, dround, net68, qsig, wr, xs, xa, pc, xsel, fl;
  logic signed [67:0] bound;
  logic signed [31:0] dterm, net, k_new, w_new;
  logic [32:0]        net_mag;
  logic [63:0]        net_dvd, x_mag;
  logic signed [35:0] sel_sum;
  logic               heavy;
  logic               div_start, div_busy, rem_nz;
  logic [63:0]        quot;

  always_comb begin
    ma = '0;
    mb = '0;
    sel_sum = cmd.stage[0] ? ssum : wsum;
    case (cmd.op)
      OP_DMUL: begin
        ma = 33'(damping);
        mb = 33'(cur_w);
      end
      OP_KMUL: begin
        ma = 33'(dt);
        mb = 33'(k);
      end
      OP_HMUL: begin
        ma = 33'(dt);
        mb = 33'(signed'(sel_sum[35:16]));
      end
      OP_LMUL: begin
        ma = 33'(dt);
        mb = {17'd0, sel_sum[15:0]};
      end
      default: begin
        ma = '0;
        mb = '0;
      end
    endcase
    mp = ma * mb;

    p68  = 68'(prod);
    pv68 = 68'(pval);

    // Damping term rounded half up, then the net torque.
    dround  = (p68 + (68'sd1 <<< (VALUE_FRAC_BITS - 1))) >>> VALUE_FRAC_BITS;
    dterm   = sat32(dround);
    net68   = 68'(torque) - 68'(load_torque) - 68'(dterm);
    net     = sat32(net68);
    net_mag = net[31] ? 33'(-(34'(net))) : 33'(net);
    net_dvd = 64'(net_mag) << VALUE_FRAC_BITS;

    qsig  = div_neg ? -(68'({4'd0, quot})) : 68'({4'd0, quot});
    k_new = sat32(qsig);
    heavy = (cmd.stage == 2'd1) || (cmd.stage == 2'd2);

    // Midpoint speeds use half a step, the endpoint a full step.
    if (cmd.stage == 2'd2) begin
      wr = (p68 + (68'sd1 <<< 29)) >>> 30;
    end else begin
      wr = (p68 + (68'sd1 <<< 30)) >>> 31;
    end
    w_new = sat32(68'(speed_reg) + wr);

    xs = (pv68 + (68'sd3 <<< 14)) >>> 15;
    bound = 68'sd1 <<< (61 - GM);
    if (pv68 > bound) begin
      pc = bound;
    end else if (pv68 < -bound) begin
      pc = -bound;
    end else begin
      pc = pv68;
    end
    if (G >= 0) begin
      xa = ((pv68 <<< 1) + (68'sd3 <<< GP)) >>> (GP + 1);
    end else begin
      xa = (pc <<< GM) + 68'sd1;
    end
    xsel  = cmd.stage[0] ? xa : xs;
    x_mag = xsel[67] ? 64'(-xsel) : xsel[63:0];

    // Long division by three: remainder and the next 16 bits form one digit.
    d3_v   = {d3_r, d3_x[63:48]};
    d3_m   = 36'(d3_v) * 36'(D3_RECIP);
    d3_qc  = d3_m[34:19];
    d3_rem = d3_v - 18'(d3_qc) * 18'd3;
    rem_nz = (d3_r != 2'd0);

    fl = div_neg ? -(68'({4'd0, d3_q}) + 68'(rem_nz)) : 68'({4'd0, d3_q});

    div_start = (cmd.op == OP_NET);
  end

  rk4s_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (net_dvd),
    .divisor  (inertia),
    .busy     (div_busy),
    .quot     (quot)
  );

  assign stat.integ    = integ;
  assign stat.div_busy = div_busy | d3_busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      d3_busy <= 1'b0;
      d3_cnt  <= '0;
    end else if (cmd.op == OP_XDIV) begin
      d3_busy <= 1'b1;
      d3_cnt  <= '0;
    end else if (d3_busy) begin
      d3_cnt <= d3_cnt + 2'd1;
      if (d3_cnt == 2'd3) begin
        d3_busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == OP_XDIV) begin
      d3_x <= x_mag;
      d3_q <= '0;
      d3_r <= '0;
    end else if (d3_busy) begin
      d3_x <= {d3_x[47:0], 16'd0};
      d3_q <= {d3_q[47:0], d3_qc};
      d3_r <= d3_rem[1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      inertia       <= INERTIA_RESET;
      damping       <= '0;
      load_torque   <= '0;
      probe_enabled <= 1'b0;
      initial_angle <= '0;
      initial_speed <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_INERTIA:       inertia       <= cfg_data[31:0];
        REG_DAMPING:       damping       <= cfg_data[31:0];
        REG_LOAD_TORQUE:   load_torque   <= cfg_data[31:0];
        REG_PROBE_ENABLED: probe_enabled <= cfg_data[0];
        REG_INITIAL_ANGLE: initial_angle <= cfg_data[47:0];
        REG_INITIAL_SPEED: initial_speed <= cfg_data[31:0];
        default: ;
      endcase
    end
  end

  // Reset clears angle and speed; a load beat copies the initial registers in.
  always_ff @(posedge clk) begin
    if (rst) begin
      speed_reg   <= '0;
      angle_reg   <= '0;
      held_torque <= '0;
      warned_flag <= 1'b0;
      integ       <= 1'b0;
      missing     <= 1'b0;
    end else begin
      case (cmd.op)
        OP_ACCEPT: begin
          missing <= 1'b0;
          wsum    <= '0;
          ssum    <= '0;
          dt      <= time_step;
          if (mode) begin
            speed_reg   <= initial_speed;
            angle_reg   <= initial_angle;
            held_torque <= '0;
            warned_flag <= 1'b0;
            integ       <= 1'b0;
          end else begin
            integ <= (time_step > 32'sd0) && (inertia > 32'sd0);
            cur_w <= speed_reg;
            if (!probe_enabled) begin
              torque <= '0;
            end else if (torque_found) begin
              held_torque <= torque_value;
              warned_flag <= 1'b0;
              torque      <= torque_value;
            end else begin
              torque <= held_torque;
              if (!warned_flag) begin
                warned_flag <= 1'b1;
                missing     <= 1'b1;
              end
            end
          end
        end
        OP_DMUL, OP_KMUL, OP_HMUL: begin
          prod <= mp;
        end
        OP_NET: begin
          div_neg <= net[31];
        end
        OP_KSET: begin
          k    <= k_new;
          wsum <= wsum + (36'(k_new) <<< heavy);
          ssum <= ssum + (36'(cur_w) <<< heavy);
        end
        OP_WNEXT: begin
          cur_w <= w_new;
        end
        OP_LMUL: begin
          pacc <= prod;
          prod <= mp;
        end
        OP_PADD: begin
          pval <= pacc + ((prod + 66'sd32768) >>> 16);
        end
        OP_XDIV: begin
          div_neg <= xsel[67];
        end
        OP_APPLY: begin
          if (cmd.stage[0]) begin
            angle_reg <= sat48(68'(angle_reg) + fl);
          end else begin
            speed_reg <= sat32(68'(speed_reg) + fl);
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == OP_PUBLISH) begin
      rotor_angle   <= angle_reg;
      rotor_speed   <= speed_reg;
      integrated    <= integ;
      probe_missing <= missing;
    end
  end

endmodule

`default_nettype wire

// File: design/rk4s_ctrl.sv
// ----------------------------------------------------------------------------
// rk4s_ctrl
// Sequencer of the RK4 step: four acceleration passes, then the two updates;
// load beats and skipped steps go straight to publication.
`default_nettype none
`include "assert_macros.svh"

module rk4s_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  input  wire rk4s_pkg::rk4s_stat_t stat,
  output rk4s_pkg::rk4s_cmd_t       cmd
);

  import rk4s_pkg::*;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_CHECK = 4'd1;
  localparam logic [3:0] S_DMUL  = 4'd2;
  localparam logic [3:0] S_NET   = 4'd3;
  localparam logic [3:0] S_DWAIT = 4'd4;
  localparam logic [3:0] S_KSET  = 4'd5;
  localparam logic [3:0] S_KMUL  = 4'd6;
  localparam logic [3:0] S_WNEXT = 4'd7;
  localparam logic [3:0] S_HMUL  = 4'd8;
  localparam logic [3:0] S_LMUL  = 4'd9;
  localparam logic [3:0] S_PADD  = 4'd10;
  localparam logic [3:0] S_XDIV  = 4'd11;
  localparam logic [3:0] S_XWAIT = 4'd12;
  localparam logic [3:0] S_APPLY = 4'd13;
  localparam logic [3:0] S_PUB   = 4'd14;

  logic [3:0] state, state_next;
  logic [1:0] stage, stage_next;
  logic       out_valid_next;
  logic       slot_free;

  assign in_stall  = (state != S_IDLE);
  assign slot_free = !out_valid || !out_stall;

  always_comb begin
    state_next     = state;
    stage_next     = stage;
    cmd.op         = OP_NONE;
    cmd.stage      = stage;
    out_valid_next = out_valid && out_stall;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.op     = OP_ACCEPT;
          stage_next = 2'd0;
          state_next = S_CHECK;
        end
      end
      S_CHECK: state_next = stat.integ ? S_DMUL : S_PUB;
      S_DMUL: begin
        cmd.op     = OP_DMUL;
        state_next = S_NET;
      end
      S_NET: begin
        cmd.op     = OP_NET;
        state_next = S_DWAIT;
      end
      S_DWAIT: begin
        if (!stat.div_busy) begin
          state_next = S_KSET;
        end
      end
      S_KSET: begin
        cmd.op = OP_KSET;
        if (stage == 2'd3) begin
          stage_next = 2'd0;
          state_next = S_HMUL;
        end else begin
          state_next = S_KMUL;
        end
      end
      S_KMUL: begin
        cmd.op     = OP_KMUL;
        state_next = S_WNEXT;
      end
      S_WNEXT: begin
        cmd.op     = OP_WNEXT;
        stage_next = stage + 2'd1;
        state_next = S_DMUL;
      end
      S_HMUL: begin
        cmd.op     = OP_HMUL;
        state_next = S_LMUL;
      end
      S_LMUL: begin
        cmd.op     = OP_LMUL;
        state_next = S_PADD;
      end
      S_PADD: begin
        cmd.op     = OP_PADD;
        state_next = S_XDIV;
      end
      S_XDIV: begin
        cmd.op     = OP_XDIV;
        state_next = S_XWAIT;
      end
      S_XWAIT: begin
        if (!stat.div_busy) begin
          state_next = S_APPLY;
        end
      end
      S_APPLY: begin
        cmd.op = OP_APPLY;
        if (stage == 2'd0) begin
          stage_next = 2'd1;
          state_next = S_HMUL;
        end else begin
          state_next = S_PUB;
        end
      end
      S_PUB: begin
        if (slot_free) begin
          cmd.op         = OP_PUBLISH;
          out_valid_next = 1'b1;
          state_next     = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      stage     <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      stage     <= stage_next;
      out_valid <= out_valid_next;
    end
  end

  // A result register must never be overwritten while its beat is stalled.
  `ASSERT_IMPLY(a_pub_slot, clk, rst, cmd.op == OP_PUBLISH, !out_valid || !out_stall)
  // Once a beat is taken in, no other is taken until the result is out.
  `ASSERT_NEXT(a_one_item, clk, rst, in_valid && !in_stall, in_stall)
  // The acceleration is only read after the divider has finished.
  `ASSERT_IMPLY(a_kset_div, clk, rst, cmd.op == OP_KSET, !stat.div_busy)
  // A stalled result stays valid.
  `ASSERT_NEXT(a_out_hold, clk, rst, out_valid && out_stall, out_valid)

endmodule

`default_nettype wire

// File: tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the RK4 rotor integrator. A queue-fed driver sends
// step and load beats with random gaps, a monitor takes result beats with
// random stalls, and a built-in fixed-point model predicts every result.
// The configuration is changed between phases while the block is idle.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module testbench;
  import rk4s_pkg::*;

  localparam int VF = 16;
  localparam int AF = 32;
  localparam longint MAX32 = 64'sd2147483647;
  localparam longint MIN32 = -64'sd2147483648;
  localparam longint MAX48 = 64'sd140737488355327;
  localparam longint MIN48 = -64'sd140737488355328;

  typedef struct {
    logic        mode;
    logic [31:0] step;
    logic        found;
    logic [31:0] torque;
  } beat_t;

  typedef struct {
    logic [47:0] angle;
    logic [31:0] speed;
    logic        integ;
    logic        missing;
  } state_out_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = REG_INERTIA;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic mode = 1'b0;
  logic signed [31:0] time_step = '0;
  logic torque_found = 1'b0;
  logic signed [31:0] torque_value = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [47:0] rotor_angle;
  logic signed [31:0] rotor_speed;
  logic integrated;
  logic probe_missing;

  rk4_rotor_dynamics_step dut (.*);

  always #1 clk = ~clk;

  // Predictor state and shadow configuration.
  longint m_inertia, m_damping, m_load, m_init_angle, m_init_speed;
  bit m_probe;
  longint m_speed, m_angle, m_held;
  bit m_warned;

  beat_t pending_beats[$];
  state_out_t expected_results[$];
  int errors = 0;
  int results_seen = 0;
  int steps_integrated = 0;
  bit calm = 1'b0;
  int send_gap = 0;
  int stall_left = 0;

  function automatic longint clamp(longint x, longint lo, longint hi);
    return x < lo ? lo : (x > hi ? hi : x);
  endfunction

  function automatic longint fdiv(longint a, longint b);
    longint q;
    q = a / b;
    if (a % b != 0 && ((a < 0) != (b < 0))) q--;
    return q;
  endfunction

  function automatic longint round_shift(longint x, int n);
    return (x + (64'sd1 <<< (n - 1))) >>> n;
  endfunction

  function automatic longint accel(longint torque, longint w);
    longint dterm, net, q;
    dterm = clamp(round_shift(m_damping * w, VF), MIN32, MAX32);
    net = clamp(torque - m_load - dterm, MIN32, MAX32);
    q = (net * (64'sd1 <<< VF)) / m_inertia;
    return clamp(q, MIN32, MAX32);
  endfunction

  function automatic longint scaled_sum(longint dt, longint wsum);
    longint lo, hi;
    lo = wsum & 64'hFFFF;
    hi = (wsum - lo) >>> 16;
    return dt * hi + ((dt * lo + 32768) >>> 16);
  endfunction

  function automatic longint third_scaled(longint p, int g);
    longint d, bound;
    int m;
    if (g >= 0) begin
      d = 64'sd3 <<< g;
      return fdiv(2 * p + d, 2 * d);
    end
    m = -g;
    bound = 64'sd1 <<< (61 - m);
    p = clamp(p, -bound, bound);
    return fdiv(2 * (p * (64'sd1 <<< m)) + 3, 6);
  endfunction

  function automatic state_out_t predict_rotor(beat_t b);
    state_out_t r;
    longint dt, torque, w, w2, w3, w4, k1, k2, k3, k4, ps, pa;
    r.integ = 1'b0;
    r.missing = 1'b0;
    if (b.mode) begin
      m_speed = m_init_speed;
      m_angle = m_init_angle;
      m_held = 0;
      m_warned = 1'b0;
    end else begin
      dt = longint'(signed'(b.step));
      torque = 0;
      if (m_probe) begin
        if (b.found) begin
          m_held = longint'(signed'(b.torque));
          m_warned = 1'b0;
        end else if (!m_warned) begin
          m_warned = 1'b1;
          r.missing = 1'b1;
        end
        torque = m_held;
      end
      if (dt > 0 && m_inertia > 0) begin
        w = m_speed;
        k1 = accel(torque, w);
        w2 = clamp(w + round_shift(dt * k1, 31), MIN32, MAX32);
        k2 = accel(torque, w2);
        w3 = clamp(w + round_shift(dt * k2, 31), MIN32, MAX32);
        k3 = accel(torque, w3);
        w4 = clamp(w + round_shift(dt * k3, 30), MIN32, MAX32);
        k4 = accel(torque, w4);
        ps = scaled_sum(dt, k1 + 2 * k2 + 2 * k3 + k4);
        pa = scaled_sum(dt, w + 2 * w2 + 2 * w3 + w4);
        m_speed = clamp(w + third_scaled(ps, 15), MIN32, MAX32);
        m_angle = clamp(m_angle + third_scaled(pa, VF + 15 - AF), MIN48, MAX48);
        r.integ = 1'b1;
      end
    end
    r.angle = m_angle[47:0];
    r.speed = m_speed[31:0];
    return r;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("MISMATCH %s at %0t: got %0h expected %0h", what, $time, got, want);
    errors++;
  endtask

  task automatic queue_beat(beat_t b);
    pending_beats = {pending_beats, b};
  endtask

  task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [47:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_INERTIA:       m_inertia = longint'(signed'(val[31:0]));
      REG_DAMPING:       m_damping = longint'(signed'(val[31:0]));
      REG_LOAD_TORQUE:   m_load = longint'(signed'(val[31:0]));
      REG_PROBE_ENABLED: m_probe = val[0];
      REG_INITIAL_ANGLE: m_init_angle = longint'(signed'(val));
      REG_INITIAL_SPEED: m_init_speed = longint'(signed'(val[31:0]));
      default: ;
    endcase
  endtask

  // Driver: the prediction is made when the beat is accepted.
  always @(posedge clk) begin
    state_out_t pred;
    if (in_valid && !in_stall) begin
      pred = predict_rotor('{mode, time_step, torque_found, torque_value});
      expected_results = {expected_results, pred};
    end
    if (!rst && (!in_valid || !in_stall)) begin
      if (send_gap > 0) begin
        send_gap <= send_gap - 1;
        in_valid <= 1'b0;
      end else if (pending_beats.size() > 0) begin
        in_valid <= 1'b1;
        mode <= pending_beats[0].mode;
        time_step <= pending_beats[0].step;
        torque_found <= pending_beats[0].found;
        torque_value <= pending_beats[0].torque;
        void'(pending_beats.pop_front());
        if (!calm && $urandom_range(0, 5) == 0) send_gap <= $urandom_range(1, 15);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Monitor with random receiver stalls.
  always @(posedge clk) begin
    state_out_t want;
    if (out_valid && !out_stall) begin
      results_seen++;
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected beat", rotor_angle, 0);
      end else begin
        want = expected_results.pop_front();
        if (want.integ) steps_integrated++;
        if (rotor_angle !== want.angle) report_mismatch("rotor_angle", rotor_angle, want.angle);
        if (rotor_speed !== want.speed) report_mismatch("rotor_speed", rotor_speed, want.speed);
        if (integrated !== want.integ) report_mismatch("integrated", integrated, want.integ);
        if (probe_missing !== want.missing)
          report_mismatch("probe_missing", probe_missing, want.missing);
      end
    end
    if (rst || calm) begin
      out_stall <= 1'b0;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_stall <= 1'b1;
    end else if ($urandom_range(0, 7) == 0) begin
      stall_left <= $urandom_range(0, 14);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  function automatic beat_t random_beat();
    beat_t b;
    int pick;
    pick = $urandom_range(0, 19);
    b.mode = (pick == 0);
    case ($urandom_range(0, 9))
      0: b.step = $urandom;
      1: b.step = -$urandom_range(0, 1000);
      2: b.step = 32'h7fffffff;
      default: b.step = $urandom_range(1, 32'h0400_0000);
    endcase
    b.found = $urandom_range(0, 3) != 0;
    case ($urandom_range(0, 3))
      0: b.torque = $urandom;
      default: b.torque = $urandom_range(0, 32'h0008_0000) - 32'h0004_0000;
    endcase
    return b;
  endfunction

  task automatic drain();
    while (pending_beats.size() > 0 || expected_results.size() > 0 || in_valid)
      @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic random_config();
    write_reg(REG_INERTIA, $urandom_range(0, 4) == 0 ? {16'h0, $urandom} :
                           48'($urandom_range(32'h0000_1000, 32'h0010_0000)));
    write_reg(REG_DAMPING, $urandom_range(0, 4) == 0 ? {16'h0, $urandom} :
                           48'($urandom_range(0, 32'h0002_0000)));
    write_reg(REG_LOAD_TORQUE, {16'h0, $urandom_range(0, 3) == 0 ? $urandom :
                                32'($urandom_range(0, 32'h0002_0000)) - 32'h0001_0000});
    write_reg(REG_PROBE_ENABLED, 48'($urandom_range(0, 3) != 0));
    write_reg(REG_INITIAL_ANGLE, 48'({$urandom, $urandom}));
    write_reg(REG_INITIAL_SPEED, {16'h0, $urandom});
  endtask

  initial begin
    m_inertia = 65536;
    m_damping = 0;
    m_load = 0;
    m_probe = 1'b0;
    m_init_angle = 0;
    m_init_speed = 0;
    m_speed = 0;
    m_angle = 0;
    m_held = 0;
    m_warned = 1'b0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Directed: probe off at reset defaults, then probe on with missing torque.
    queue_beat('{1'b0, 32'h4000_0000, 1'b1, 32'h0001_0000});
    queue_beat('{1'b0, 32'h0, 1'b0, 32'h0});
    queue_beat('{1'b0, 32'h8000_0000, 1'b1, 32'h7fff_ffff});
    drain();
    write_reg(REG_PROBE_ENABLED, 48'd1);
    write_reg(REG_DAMPING, 48'h0000_8000);
    write_reg(REG_LOAD_TORQUE, 48'h0000_4000);
    write_reg(REG_INITIAL_ANGLE, 48'h7fff_ffff_ffff);
    write_reg(REG_INITIAL_SPEED, 48'h7fff_ffff);
    queue_beat('{1'b1, 32'hffff_ffff, 1'b1, 32'hffff_ffff});
    queue_beat('{1'b0, 32'h7fff_ffff, 1'b1, 32'h7fff_ffff});
    queue_beat('{1'b0, 32'h7fff_ffff, 1'b0, 32'h0});
    queue_beat('{1'b0, 32'h0100_0000, 1'b0, 32'h0});
    queue_beat('{1'b0, 32'hffff_fff0, 1'b1, 32'h8000_0000});
    queue_beat('{1'b0, 32'h0000_0001, 1'b1, 32'h8000_0000});
    drain();
    write_reg(REG_INERTIA, 48'h8000_0000);
    write_reg(REG_INITIAL_ANGLE, 48'h8000_0000_0000);
    write_reg(REG_INITIAL_SPEED, 48'h8000_0000);
    queue_beat('{1'b1, 32'h0, 1'b0, 32'h0});
    queue_beat('{1'b0, 32'h4000_0000, 1'b1, 32'h1234_5678});
    drain();
    write_reg(REG_INERTIA, 48'h0000_0001);
    write_reg(REG_DAMPING, 48'h8000_0000);
    write_reg(REG_LOAD_TORQUE, 48'h7fff_ffff);
    queue_beat('{1'b0, 32'h7fff_ffff, 1'b1, 32'h8000_0000});
    queue_beat('{1'b0, 32'h2000_0000, 1'b0, 32'h0});
    queue_beat('{1'b1, 32'h0, 1'b0, 32'h0});
    drain();

    // Random phases, each with a fresh configuration.
    for (int phase = 0; phase < 17; phase++) begin
      random_config();
      if (phase == 16) calm = 1'b1;
      for (int i = 0; i < 100; i++) queue_beat(random_beat());
      drain();
    end

    $display("Covered %0d result beats, %0d of them integrating steps, over 21 settings.",
             results_seen, steps_integrated);
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #8000000;
    $display("Timeout with %0d results outstanding.", expected_results.size());
    $display("Regression FAIL");
    $finish;
  end

endmodule

// File: sim.f
+incdir+design
design/rk4s_pkg.sv
design/rk4s_div.sv
design/rk4s_datapath.sv
design/rk4s_ctrl.sv
design/rk4_rotor_dynamics_step.sv
tb/testbench.sv
